// ----- hw/rtl/julian_day_to_calendar_date_assert.svh -----
// assertion macros for the calendar conversion pipeline
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_ASSERT_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_ASSERT_SVH

// same-cycle implication
`define JDCD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication after a fixed number of cycles
`define JDCD_ASSERT_DELAY(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/jdcd_pkg.sv -----
`timescale 1ns / 1ps
package jdcd_pkg;
	localparam int unsigned GAP_LOW = 2299150;
	localparam int unsigned GAP_HIGH = 2299159;
	localparam int unsigned GREG_START = 2299161;
	localparam int unsigned ALPHA_OFS = 7468865;
	localparam int unsigned ALPHA_DIV = 146097;
	localparam int unsigned B_OFS = 1524;
	localparam int unsigned C_MUL = 20;
	localparam int unsigned C_OFS = 2442;
	localparam int unsigned C_DIV = 7305;
	localparam int unsigned D_MUL = 1461;
	localparam int unsigned YEAR_OFS = 4715;
	localparam int unsigned E_WRAP = 14;
	localparam int unsigned E_BACK_LO = 1;
	localparam int unsigned E_BACK_HI = 13;
	localparam int unsigned FEB = 2;
	localparam int unsigned HOURS_PER_DAY = 24;
	localparam int unsigned MINUTES_PER_DAY = 1440;
	localparam int unsigned DAY_SECONDS = 86400;
	localparam int unsigned BASE_60 = 60;

	// floor(30.6001 * k)
	localparam logic [8:0] MONTH_OFS [16] = '{
		9'd0, 9'd30, 9'd61, 9'd91, 9'd122, 9'd153, 9'd183, 9'd214,
		9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
	};

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	typedef struct packed {
		logic valid;
		logic gap;
	} ctl_t;
endpackage

// ----- hw/rtl/jdcd_recip_div.sv -----
`timescale 1ns / 1ps
module jdcd_recip_div #(
	parameter int NB = 26,
	parameter int unsigned K = 146097,
	parameter int TW = 8,
	parameter int QB = NB - $clog2(K) + 1
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [NB-1:0] num,
	input logic [TW-1:0] in_tag,
	output logic out_valid,
	output logic [QB-1:0] quot,
	output logic [TW-1:0] out_tag
);
	localparam longint unsigned RECIP = (64'd1 << NB) / 64'(K);
	localparam int MB = $clog2(RECIP + 1);
	localparam int PW = NB + MB;

	logic [PW-1:0] prod;
	logic v_s1;
	logic [NB-1:0] n_s1;
	logic [QB-1:0] qe_s1;
	logic [TW-1:0] tag_s1;
	logic [NB-1:0] back;
	logic [NB-1:0] rem;
	logic fix;
	logic v_s2;
	logic [QB-1:0] q_s2;
	logic [TW-1:0] tag_s2;

	// estimate is the quotient or one below it
	assign prod = PW'(num) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		n_s1 <= num;
		qe_s1 <= prod[NB +: QB];
		tag_s1 <= in_tag;
	end

	assign back = NB'(NB'(qe_s1) * NB'(K));
	assign rem = n_s1 - back;
	assign fix = rem >= NB'(K);

	always_ff @(posedge clk) begin
		q_s2 <= qe_s1 + QB'(fix);
		tag_s2 <= tag_s1;
	end

	assign out_valid = v_s2;
	assign quot = q_s2;
	assign out_tag = tag_s2;
endmodule

// ----- hw/rtl/jdcd_time_of_day.sv -----
`timescale 1ns / 1ps
module jdcd_time_of_day import jdcd_pkg::*; #(
	parameter int FB = 24
) (
	input logic clk,
	input logic [FB-1:0] frac,
	output tod_t tod
);
	localparam int HW = $clog2(HOURS_PER_DAY);
	localparam int MW = $clog2(MINUTES_PER_DAY);
	localparam int SW = $clog2(DAY_SECONDS);

	logic [FB+HW-1:0] p_hr;
	logic [FB+MW-1:0] p_mn;
	logic [FB+SW-1:0] p_sc;
	logic [HW-1:0] hr_s1;
	logic [MW-1:0] mn_s1;
	logic [SW-1:0] sc_s1;
	logic [MW-1:0] mn_left;
	logic [SW-1:0] sc_left;
	tod_t tod_s2;

	assign p_hr = (FB+HW)'(frac) * (FB+HW)'(HOURS_PER_DAY);
	assign p_mn = (FB+MW)'(frac) * (FB+MW)'(MINUTES_PER_DAY);
	assign p_sc = (FB+SW)'(frac) * (FB+SW)'(DAY_SECONDS);

	always_ff @(posedge clk) begin
		hr_s1 <= p_hr[FB +: HW];
		mn_s1 <= p_mn[FB +: MW];
		sc_s1 <= p_sc[FB +: SW];
	end

	// whole minutes of the day over 60 is the hour, likewise for seconds
	assign mn_left = mn_s1 - MW'(MW'(hr_s1) * MW'(BASE_60));
	assign sc_left = sc_s1 - SW'(SW'(mn_s1) * SW'(BASE_60));

	always_ff @(posedge clk) begin
		tod_s2.hour <= hr_s1;
		tod_s2.minute <= mn_left[5:0];
		tod_s2.second <= sc_left[5:0];
	end

	assign tod = tod_s2;
endmodule

// ----- hw/rtl/jdcd_month_day.sv -----
`timescale 1ns / 1ps
module jdcd_month_day import jdcd_pkg::*; #(
	parameter int CW = 18
) (
	input logic clk,
	input logic arst_n,
	input ctl_t ctl,
	input logic [8:0] rem_days,
	input logic [CW-1:0] cyc,
	input tod_t tod_in,
	output logic done,
	output logic date_valid,
	output logic signed [15:0] year_out,
	output logic [3:0] month_out,
	output logic [4:0] day_out,
	output logic [4:0] hour_out,
	output logic [5:0] minute_out,
	output logic [5:0] second_out
);
	logic [14:0] above;
	ctl_t ctl_s1;
	logic [3:0] e_s1;
	logic [8:0] x_s1;
	logic [CW-1:0] c_s1;
	tod_t tod_s1;
	logic [8:0] day_c;
	logic [3:0] month_c;
	logic late;
	logic [CW-1:0] yr_c;
	logic done_s2;
	logic ok_s2;
	logic [15:0] yr_s2;
	logic [3:0] mon_s2;
	logic [4:0] day_s2;
	tod_t tod_s2;

	// month index is the count of month starts that the day lies beyond
	always_comb begin
		for (int k = 1; k < 16; k++) begin
			above[k-1] = rem_days > MONTH_OFS[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			done_s2 <= 1'b0;
		end else begin
			ctl_s1 <= ctl;
			done_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		e_s1 <= 4'($countones(above));
		x_s1 <= rem_days;
		c_s1 <= cyc;
		tod_s1 <= tod_in;
	end

	assign day_c = x_s1 - MONTH_OFS[e_s1];
	assign month_c = (e_s1 < 4'(E_WRAP)) ? e_s1 - 4'(E_BACK_LO) : e_s1 - 4'(E_BACK_HI);
	assign late = month_c > 4'(FEB);
	assign yr_c = c_s1 - CW'(YEAR_OFS) - CW'(late);

	always_ff @(posedge clk) begin
		ok_s2 <= !ctl_s1.gap;
		if (ctl_s1.gap) begin
			yr_s2 <= '0;
			mon_s2 <= '0;
			day_s2 <= '0;
			tod_s2 <= '0;
		end else begin
			yr_s2 <= yr_c[15:0];
			mon_s2 <= month_c;
			day_s2 <= day_c[4:0];
			tod_s2 <= tod_s1;
		end
	end

	assign done = done_s2;
	assign date_valid = ok_s2;
	assign year_out = signed'(yr_s2);
	assign month_out = mon_s2;
	assign day_out = day_s2;
	assign hour_out = tod_s2.hour;
	assign minute_out = tod_s2.minute;
	assign second_out = tod_s2.second;
endmodule

// ----- hw/rtl/julian_day_to_calendar_date.sv -----
`timescale 1ns / 1ps
// Julian day to calendar date and time of day.
// Input: julian_day_fixed, unsigned fixed point with FRAC_BITS fraction bits,
// taken at a rising edge with start high and busy low. busy is always low:
// an item can be taken on every clock cycle.
// Output: done is high for one cycle with date_valid, year_out, month_out,
// day_out, hour_out, minute_out and second_out. Results leave in the order the
// items came in, through a ten-stage pipeline with two constant-reciprocal
// dividers of two stages each. Throughput is one item per cycle.
// Days before the Gregorian reform use the Julian calendar; days in the
// reform gap give date_valid low and all other fields zero.
// The receiver cannot stall: done is a strobe and each result is shown once.
// Reset clears all valid bits; items in flight are dropped and done stays low
// until a new item has passed the pipeline. No clearing pass is needed.
module julian_day_to_calendar_date import jdcd_pkg::*; #(
	parameter int FRAC_BITS = 24,
	parameter int DAY_BITS = 23
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [FRAC_BITS+DAY_BITS-1:0] julian_day_fixed,
	output logic busy,
	output logic done,
	output logic date_valid,
	output logic signed [15:0] year_out,
	output logic [3:0] month_out,
	output logic [4:0] day_out,
	output logic [4:0] hour_out,
	output logic [5:0] minute_out,
	output logic [5:0] second_out
);
	`include "julian_day_to_calendar_date_assert.svh"

	localparam int IW = FRAC_BITS + DAY_BITS;
	localparam int ZW = DAY_BITS + 1;
	localparam int N1W = ZW + 2;
	localparam int AW = N1W - $clog2(ALPHA_DIV) + 1;
	localparam int BW = ZW + 1;
	localparam int N2W = BW + 5;
	localparam int CW = N2W - $clog2(C_DIV) + 1;
	localparam int DW = CW + $clog2(D_MUL);
	localparam int TODW = $bits(tod_t);
	localparam int T1W = ZW + 2;
	localparam int T2W = BW + TODW + 1;

	logic accept;
	logic [DAY_BITS-1:0] jd_int;
	logic gap_c;
	logic [IW:0] rounded;
	ctl_t ctl_s1;
	logic [ZW-1:0] z_s1;
	logic [FRAC_BITS-1:0] f_s1;
	logic greg_c;
	logic [N1W-1:0] n1_c;
	logic v_a;
	logic [AW-1:0] alpha;
	logic [T1W-1:0] tag1;
	tod_t tod_a;
	logic [BW-1:0] a_c;
	ctl_t ctl_s4;
	logic [BW-1:0] b_s4;
	tod_t tod_s4;
	ctl_t ctl_s5;
	logic [BW-1:0] b_s5;
	logic [N2W-1:0] n2_s5;
	tod_t tod_s5;
	logic v_c;
	logic [CW-1:0] cyc;
	logic [T2W-1:0] tag2;
	logic [DW-1:0] d_c;
	logic [DW-1:0] x_c;
	ctl_t ctl_s8;
	logic [8:0] x_s8;
	logic [CW-1:0] c_s8;
	tod_t tod_s8;

	assign busy = 1'b0;
	assign accept = start && !busy;

	assign jd_int = julian_day_fixed[IW-1:FRAC_BITS];
	assign gap_c = (jd_int >= DAY_BITS'(GAP_LOW)) && (jd_int <= DAY_BITS'(GAP_HIGH));
	assign rounded = (IW+1)'(julian_day_fixed) + ((IW+1)'(1) << (FRAC_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			ctl_s1.gap <= gap_c;
		end
	end

	always_ff @(posedge clk) begin
		z_s1 <= rounded[IW:FRAC_BITS];
		f_s1 <= rounded[FRAC_BITS-1:0];
	end

	// century correction for Gregorian days
	assign greg_c = z_s1 >= ZW'(GREG_START);
	assign n1_c = greg_c ? (N1W'(z_s1) << 2) - N1W'(ALPHA_OFS) : '0;

	jdcd_recip_div #(
		.NB(N1W),
		.K(ALPHA_DIV),
		.TW(T1W)
	) u_alpha_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(ctl_s1.valid),
		.num(n1_c),
		.in_tag({ctl_s1.gap, greg_c, z_s1}),
		.out_valid(v_a),
		.quot(alpha),
		.out_tag(tag1)
	);

	jdcd_time_of_day #(
		.FB(FRAC_BITS)
	) u_tod (
		.clk(clk),
		.frac(f_s1),
		.tod(tod_a)
	);

	always_comb begin
		a_c = BW'(tag1[ZW-1:0]);
		if (tag1[ZW]) begin
			a_c = BW'(tag1[ZW-1:0]) + BW'(1) + BW'(alpha) - BW'(alpha >> 2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s4.valid <= v_a;
			ctl_s4.gap <= tag1[ZW+1];
			ctl_s5 <= ctl_s4;
		end
	end

	always_ff @(posedge clk) begin
		b_s4 <= a_c + BW'(B_OFS);
		tod_s4 <= tod_a;
		b_s5 <= b_s4;
		n2_s5 <= N2W'(N2W'(b_s4) * N2W'(C_MUL)) - N2W'(C_OFS);
		tod_s5 <= tod_s4;
	end

	jdcd_recip_div #(
		.NB(N2W),
		.K(C_DIV),
		.TW(T2W)
	) u_year_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(ctl_s5.valid),
		.num(n2_s5),
		.in_tag({ctl_s5.gap, tod_s5, b_s5}),
		.out_valid(v_c),
		.quot(cyc),
		.out_tag(tag2)
	);

	// days into the year counted from march
	assign d_c = DW'(DW'(cyc) * DW'(D_MUL)) >> 2;
	assign x_c = DW'(tag2[BW-1:0]) - d_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s8 <= '0;
		end else begin
			ctl_s8.valid <= v_c;
			ctl_s8.gap <= tag2[BW+TODW];
		end
	end

	always_ff @(posedge clk) begin
		x_s8 <= x_c[8:0];
		c_s8 <= cyc;
		tod_s8 <= tod_t'(tag2[BW +: TODW]);
	end

	jdcd_month_day #(
		.CW(CW)
	) u_month_day (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl_s8),
		.rem_days(x_s8),
		.cyc(c_s8),
		.tod_in(tod_s8),
		.done(done),
		.date_valid(date_valid),
		.year_out(year_out),
		.month_out(month_out),
		.day_out(day_out),
		.hour_out(hour_out),
		.minute_out(minute_out),
		.second_out(second_out)
	);

	`JDCD_ASSERT_IMPL(a_gap_zero, done && !date_valid, year_out == 16'sd0 && month_out == 4'd0 && day_out == 5'd0 && hour_out == 5'd0 && minute_out == 6'd0 && second_out == 6'd0, "gap item with nonzero fields")
	`JDCD_ASSERT_IMPL(a_date_range, done && date_valid, month_out >= 4'd1 && month_out <= 4'd12 && day_out >= 5'd1 && day_out <= 5'd31, "month or day out of range")
	`JDCD_ASSERT_IMPL(a_time_range, done, hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59, "time of day out of range")
	`JDCD_ASSERT_DELAY(a_tail_latency, ctl_s4.valid, 6, done, "item lost in pipeline tail")
endmodule
